// File: sv/vgfp_pkg.sv
// Package with the payload types, constants and hash step of the voxel grid filter.
`timescale 1ns / 1ps
package vgfp_pkg;

  localparam int COORD_W = 20;
  localparam int VSIZE_W = 19;
  localparam int EPOCH_W = 8;
  localparam logic [VSIZE_W-1:0] VSIZE_RESET = 19'd256;
  localparam logic [31:0] HASH_GOLDEN = 32'h9e37_79b9;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      point_valid;
    logic                      frame_start;
  } point_t;

  typedef struct packed {
    logic                      keep;
    logic                      table_overflow;
    logic signed [COORD_W-1:0] voxel_x;
    logic signed [COORD_W-1:0] voxel_y;
    logic signed [COORD_W-1:0] voxel_z;
  } result_t;

  function automatic logic [31:0] mix_step(logic [31:0] h, logic [31:0] k);
    return h ^ (k + HASH_GOLDEN + (h << 6) + (h >> 2));
  endfunction

endpackage

// File: sv/vgfp_if.sv
// Valid/ready channel interfaces for points, results and the voxel size register.
`timescale 1ns / 1ps
interface vgfp_point_if;
  logic             valid;
  logic             ready;
  vgfp_pkg::point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vgfp_result_if;
  logic              valid;
  logic              ready;
  vgfp_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vgfp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [vgfp_pkg::VSIZE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/vgfp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module vgfp_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/voxel_grid_first_point_filter.sv
// Top level of the voxel grid filter that keeps the first point of each voxel.
//
//   channel  direction  carries
//   point    in         coordinates, point_valid, frame_start
//   result   out        keep, table_overflow, voxel indices
//   cfg      in         voxel_size write data
//
// An item passes the three bit-serial dividers, the key register, the hash steps, a reciprocal
// hash modulo (MOD, FOLD, WRAP) and a registered table read per probe; an invalid point or a
// zero voxel size goes from START straight to DONE. Table entries carry a frame epoch.
// After reset, and on every frame start that wraps the epoch, a clearing pass writes all
// TABLE_ENTRIES entries while no point is accepted. A waiting result holds the next
// point in its last state until the output register is free.
`timescale 1ns / 1ps
module voxel_grid_first_point_filter #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int PROBE_LIMIT = 16,
  parameter int COORD_BITS = 20
) (
  input logic          clk,
  input logic          rst,
  vgfp_point_if.sink   point,
  vgfp_result_if.source result,
  vgfp_cfg_if.sink     cfg
);
  localparam int CW = vgfp_pkg::COORD_W;
  localparam int VW = vgfp_pkg::VSIZE_W;
  localparam int EW = vgfp_pkg::EPOCH_W;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int SH = 32 + AW;
  localparam int KW = 3 * COORD_BITS;
  localparam int RW = KW + EW;
  localparam int DCW = $clog2(COORD_BITS + 1);
  localparam int PCW = $clog2(PROBE_LIMIT + 1);
  localparam logic [EW-1:0] EPOCH_MAX = {EW{1'b1}};
  localparam logic [EW-1:0] EPOCH_FIRST = EW'(1);
  localparam logic [32:0] MOD_RECIP = 33'((65'd1 << SH) / 65'(TABLE_ENTRIES));

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_DIV, S_KEY, S_HASH1, S_HASH2, S_MOD, S_FOLD, S_WRAP,
    S_RD, S_CHK, S_DONE
  } state_t;

  state_t                state;
  logic [VW-1:0]         voxel_size;
  logic [EW-1:0]         epoch;
  logic                  pend;
  logic [AW-1:0]         clr_addr;
  vgfp_pkg::point_t      item;
  logic [COORD_BITS-1:0] mag [3];
  logic                  neg [3];
  logic [VW:0]           rem [3];
  logic [COORD_BITS-1:0] quo [3];
  logic [COORD_BITS-1:0] key [3];
  logic [DCW-1:0]        div_cnt;
  logic [31:0]           hash;
  logic [64:0]           mod_prod;
  logic [31:0]           hrem;
  logic [AW-1:0]         slot;
  logic [PCW-1:0]        probe_cnt;
  logic                  res_keep;
  logic                  res_ovf;

  logic [COORD_BITS-1:0] coord_raw [3];
  logic [VW:0]           rem_sh [3];
  logic [VW:0]           rem_next [3];
  logic                  qbit [3];
  logic [COORD_BITS-1:0] flr [3];
  logic [31:0]           mod_quo;
  logic [31:0]           mod_back;
  logic [AW-1:0]         slot_next;
  logic [PCW-1:0]        probe_next;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [RW-1:0]         ram_wdata;
  logic [RW-1:0]         ram_rdata;
  logic                  out_free;

  vgfp_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign point.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free = !result.valid || result.ready;

  always_comb begin
    coord_raw[0] = COORD_BITS'({1'b0, point.data.point_x});
    coord_raw[1] = COORD_BITS'({1'b0, point.data.point_y});
    coord_raw[2] = COORD_BITS'({1'b0, point.data.point_z});
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_sh[l] = {rem[l][VW-1:0], mag[l][COORD_BITS-1]};
      qbit[l] = (rem_sh[l] >= {1'b0, voxel_size});
      rem_next[l] = qbit[l] ? rem_sh[l] - {1'b0, voxel_size} : rem_sh[l];
      if (neg[l] && rem[l] != '0) begin
        flr[l] = ~quo[l];
      end else if (neg[l]) begin
        flr[l] = -quo[l];
      end else begin
        flr[l] = quo[l];
      end
    end
  end

  always_comb begin
    mod_quo = 32'(mod_prod >> SH);
    mod_back = mod_quo * 32'(TABLE_ENTRIES);
    slot_next = (slot == AW'(TABLE_ENTRIES - 1)) ? '0 : slot + AW'(1);
    probe_next = probe_cnt + PCW'(1);
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = slot;
    ram_wdata = {epoch, key[0], key[1], key[2]};
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_CHK && ram_rdata[RW-1:KW] != epoch) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      voxel_size <= vgfp_pkg::VSIZE_RESET;
      epoch <= '0;
      pend <= 1'b0;
      clr_addr <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        voxel_size <= cfg.data;
      end
      if (state == S_DONE && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(TABLE_ENTRIES - 1)) begin
            clr_addr <= '0;
            epoch <= EPOCH_FIRST;
            state <= pend ? S_START : S_IDLE;
          end
        end
        S_IDLE: begin
          if (point.valid) begin
            item <= point.data;
            for (int l = 0; l < 3; l++) begin
              neg[l] <= coord_raw[l][COORD_BITS-1];
              mag[l] <= coord_raw[l][COORD_BITS-1] ? -coord_raw[l] : coord_raw[l];
              rem[l] <= '0;
            end
            div_cnt <= '0;
            pend <= 1'b0;
            state <= S_START;
            if (point.data.frame_start) begin
              if (epoch == EPOCH_MAX) begin
                pend <= 1'b1;
                state <= S_CLEAR;
              end else begin
                epoch <= epoch + EW'(1);
              end
            end
          end
        end
        S_START: begin
          if (!item.point_valid || voxel_size == '0) begin
            res_keep <= 1'b0;
            res_ovf <= 1'b0;
            for (int l = 0; l < 3; l++) begin
              key[l] <= '0;
            end
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          for (int l = 0; l < 3; l++) begin
            rem[l] <= rem_next[l];
            mag[l] <= mag[l] << 1;
            quo[l] <= {quo[l][COORD_BITS-2:0], qbit[l]};
          end
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(COORD_BITS - 1)) begin
            state <= S_KEY;
          end
        end
        S_KEY: begin
          for (int l = 0; l < 3; l++) begin
            key[l] <= flr[l];
          end
          state <= S_HASH1;
        end
        S_HASH1: begin
          hash <= vgfp_pkg::mix_step(32'(key[0]), 32'(key[1]));
          state <= S_HASH2;
        end
        S_HASH2: begin
          hash <= vgfp_pkg::mix_step(hash, 32'(key[2]));
          state <= S_MOD;
        end
        S_MOD: begin
          mod_prod <= 65'(hash) * 65'(MOD_RECIP);
          state <= S_FOLD;
        end
        S_FOLD: begin
          hrem <= hash - mod_back;
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (hrem >= 32'(TABLE_ENTRIES)) begin
            slot <= AW'(hrem - 32'(TABLE_ENTRIES));
          end else begin
            slot <= AW'(hrem);
          end
          probe_cnt <= '0;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (ram_rdata[RW-1:KW] != epoch) begin
            res_keep <= 1'b1;
            res_ovf <= 1'b0;
            state <= S_DONE;
          end else if (ram_rdata[KW-1:0] == {key[0], key[1], key[2]}) begin
            res_keep <= 1'b0;
            res_ovf <= 1'b0;
            state <= S_DONE;
          end else if (probe_next == PCW'(PROBE_LIMIT)) begin
            res_keep <= 1'b1;
            res_ovf <= 1'b1;
            state <= S_DONE;
          end else begin
            probe_cnt <= probe_next;
            slot <= slot_next;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            result.data.keep <= res_keep;
            result.data.table_overflow <= res_ovf;
            result.data.voxel_x <= CW'($signed(key[0]));
            result.data.voxel_y <= CW'($signed(key[1]));
            result.data.voxel_z <= CW'($signed(key[2]));
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/vgfp_checker.sv
// Port-level checker for the voxel grid filter and its bind statement.
`timescale 1ns / 1ps
module vgfp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input vgfp_pkg::result_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or vanished.");

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("Point accepted during the clearing pass.");

  a_ovf_keeps: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.table_overflow || out_data.keep))
    else $error("Overflowed point was not kept.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Second point accepted while one is in work.");
endmodule

bind voxel_grid_first_point_filter vgfp_checker u_vgfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (point.valid),
  .in_ready  (point.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);

// File: tb/sv/voxel_grid_first_point_filter_test.sv
// Self-checking testbench for the voxel grid first-point filter with a scoreboard class.
`timescale 1ns / 1ps
module voxel_grid_first_point_filter_test;

  localparam int ENTRIES = 4096;
  localparam int PROBES = 16;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  class voxel_scoreboard;
    bit                    used[ENTRIES];
    logic [59:0]           slot[ENTRIES];
    logic [18:0]           vsize;
    vgfp_pkg::result_t     pending[$];
    int                    errors;

    function void clear_set();
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function int floor_index(logic signed [19:0] a);
      int s;
      int d;
      int q;
      s = a;
      d = vsize;
      q = s / d;
      if ((s % d) != 0 && s < 0) q = q - 1;
      return q;
    endfunction

    function void note_point(vgfp_pkg::point_t p);
      vgfp_pkg::result_t r;
      int ix;
      int iy;
      int iz;
      logic [31:0] h;
      logic [59:0] key;
      int home;
      int s;
      bit done;
      if (p.frame_start) clear_set();
      r = '0;
      if (p.point_valid && vsize != 0) begin
        ix = floor_index(p.point_x);
        iy = floor_index(p.point_y);
        iz = floor_index(p.point_z);
        key = {ix[19:0], iy[19:0], iz[19:0]};
        h = {12'd0, ix[19:0]};
        h = h ^ ({12'd0, iy[19:0]} + 32'h9e3779b9 + (h << 6) + (h >> 2));
        h = h ^ ({12'd0, iz[19:0]} + 32'h9e3779b9 + (h << 6) + (h >> 2));
        home = h % ENTRIES;
        r.keep = 1'b1;
        r.table_overflow = 1'b1;
        done = 1'b0;
        for (int i = 0; i < PROBES && !done; i++) begin
          s = (home + i) % ENTRIES;
          if (!used[s]) begin
            used[s] = 1'b1;
            slot[s] = key;
            r.table_overflow = 1'b0;
            done = 1'b1;
          end else if (slot[s] == key) begin
            r.keep = 1'b0;
            r.table_overflow = 1'b0;
            done = 1'b1;
          end
        end
        r.voxel_x = ix[19:0];
        r.voxel_y = iy[19:0];
        r.voxel_z = iz[19:0];
      end
      pending = {pending, r};
    endfunction

    function void check_result(vgfp_pkg::result_t got);
      vgfp_pkg::result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.keep !== e.keep) begin
        $error("keep: expected %0d, actual %0d", e.keep, got.keep); errors++;
      end
      if (got.table_overflow !== e.table_overflow) begin
        $error("table_overflow: expected %0d, actual %0d", e.table_overflow,
               got.table_overflow);
        errors++;
      end
      if (got.voxel_x !== e.voxel_x) begin
        $error("voxel_x: expected %0d, actual %0d", e.voxel_x, got.voxel_x); errors++;
      end
      if (got.voxel_y !== e.voxel_y) begin
        $error("voxel_y: expected %0d, actual %0d", e.voxel_y, got.voxel_y); errors++;
      end
      if (got.voxel_z !== e.voxel_z) begin
        $error("voxel_z: expected %0d, actual %0d", e.voxel_z, got.voxel_z); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycles = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  voxel_scoreboard board;
  int fail_count;

  vgfp_point_if  point ();
  vgfp_result_if result ();
  vgfp_cfg_if    cfg ();

  voxel_grid_first_point_filter DUT (
    .clk(clk), .rst(rst), .point(point.sink), .result(result.source), .cfg(cfg.sink)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) board.check_result(result.data);
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  task automatic send_point(vgfp_pkg::point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      point.valid <= 1'b0;
      @(posedge clk);
    end
    point.valid <= 1'b1;
    point.data <= p;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
    board.note_point(p);
  endtask

  task automatic write_voxel_size(logic [18:0] v);
    point.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    board.vsize = v;
  endtask

  function automatic logic signed [19:0] pick_coord(int span);
    case ($urandom_range(9))
      0: return 20'sh80000;
      1: return 20'sh7FFFF;
      2: return 20'($urandom);
      default: return $signed(20'($urandom_range(2 * span))) - 20'(span);
    endcase
  endfunction

  task automatic random_points(int n, int span);
    vgfp_pkg::point_t p;
    for (int i = 0; i < n; i++) begin
      p.point_x = pick_coord(span);
      p.point_y = pick_coord(span);
      p.point_z = pick_coord(span);
      p.point_valid = ($urandom_range(19) != 0);
      p.frame_start = ($urandom_range(39) == 0);
      send_point(p);
    end
  endtask

  initial begin
    vgfp_pkg::point_t p;
    point.valid = 1'b0;
    point.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    board = new();
    board.vsize = vgfp_pkg::VSIZE_RESET;
    board.clear_set();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 23;
    take_idle_pct = 58;
    p = '{20'sd0, 20'sd0, 20'sd0, 1'b1, 1'b1};
    send_point(p);
    send_point(p);
    p = '{20'sd255, -20'sd1, 20'sd256, 1'b1, 1'b0};
    send_point(p);
    p = '{-20'sd256, -20'sd257, 20'sd1, 1'b1, 1'b0};
    send_point(p);
    p = '{20'sh80000, 20'sh7FFFF, 20'sh80000, 1'b1, 1'b0};
    send_point(p);
    p = '{20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 1'b1, 1'b0};
    send_point(p);
    p = '{20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 1'b0, 1'b0};
    send_point(p);
    p = '{20'sd0, 20'sd0, 20'sd0, 1'b1, 1'b1};
    send_point(p);

    // Size one maps every point to its own voxel; the largest size folds all into few.
    write_voxel_size(19'd1);
    p = '{20'sh80000, 20'sh7FFFF, -20'sd1, 1'b1, 1'b0};
    send_point(p);
    send_point(p);
    write_voxel_size(19'h7FFFF);
    p = '{20'sh80000, 20'sh7FFFF, -20'sd1, 1'b1, 1'b1};
    send_point(p);
    p = '{20'sh7FFFF, 20'sd5, 20'sh80001, 1'b1, 1'b0};
    send_point(p);
    write_voxel_size(19'd0);
    p = '{20'sd100, 20'sd100, 20'sd100, 1'b1, 1'b1};
    send_point(p);

    // Many points sharing x and y keep probing one table region until it overflows.
    write_voxel_size(19'd3);
    for (int i = 0; i < 24; i++) begin
      p = '{20'sd0, 20'sd0, 20'(i * 3 * 4096), 1'b1, 1'b0};
      send_point(p);
    end

    write_voxel_size(19'd256);
    random_points(170, 2000);
    send_idle_pct = 58;
    take_idle_pct = 23;
    write_voxel_size(19'd7);
    random_points(160, 80);
    send_idle_pct = 0;
    take_idle_pct = 0;
    write_voxel_size(19'd1000);
    random_points(170, 524287);

    point.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    fail_count = board.errors + board.pending.size();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
sv/vgfp_pkg.sv
sv/vgfp_if.sv
sv/vgfp_ram.sv
sv/voxel_grid_first_point_filter.sv
sv/vgfp_checker.sv
tb/sv/voxel_grid_first_point_filter_test.sv
